/* rtl/core/mandelbrot_escape_time_pixel_top_defines.svh */
// Assertion macros for the escape-time pixel checker.
// No dependencies; taken in by the checker file only.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

// same-cycle implication
`define MANDEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MANDEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mandel_pkg.sv */
// Shared types, codes and microcode program of the escape-time pixel block.
// No dependencies; imported by the top level and its checker.
package mandel_pkg;

   localparam int DIM_BITS      = 12;
   localparam int SIZE_BITS     = DIM_BITS + 1;
   localparam int ITER_BITS     = 16;
   localparam int COUNT_BITS    = ITER_BITS + 1;
   localparam int GREY_BITS     = 8;
   localparam int DEN_BITS      = ITER_BITS;
   localparam int CSR_DATA_BITS = ITER_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int PC_BITS       = 4;

   localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);
   localparam logic [ITER_BITS-1:0] MAX_RESET    = ITER_BITS'(1000);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH    = 2'd0,
      CSR_IMAGE_HEIGHT   = 2'd1,
      CSR_MAX_ITERATIONS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] pixel_x;
      logic [DIM_BITS-1:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iteration_count;
      logic [GREY_BITS-1:0]  grey_level;
   } rsp_payload_type;

   typedef logic [PC_BITS-1:0] pc_type;

   localparam pc_type STEP_IDLE      = 4'd0;
   localparam pc_type STEP_LOAD_X    = 4'd1;
   localparam pc_type STEP_DIV_X     = 4'd2;
   localparam pc_type STEP_STORE_CX  = 4'd3;
   localparam pc_type STEP_LOAD_Y    = 4'd4;
   localparam pc_type STEP_DIV_Y     = 4'd5;
   localparam pc_type STEP_STORE_CY  = 4'd6;
   localparam pc_type STEP_ITERATE   = 4'd7;
   localparam pc_type STEP_LOAD_GREY = 4'd8;
   localparam pc_type STEP_DIV_GREY  = 4'd9;
   localparam pc_type STEP_EMIT      = 4'd10;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD_X,
      OP_LOAD_Y,
      OP_DIVIDE,
      OP_STORE_CX,
      OP_STORE_CY,
      OP_ITERATE,
      OP_LOAD_GREY,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_ALWAYS,
      COND_START,
      COND_DIV_LAST,
      COND_ITER_DONE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   // jump to target when cond holds, else hold the step
   function automatic uword_type ucode(pc_type pc);
      uword_type w;
      case (pc)
         STEP_IDLE:      w = '{op: OP_IDLE,      cond: COND_START,     target: STEP_LOAD_X};
         STEP_LOAD_X:    w = '{op: OP_LOAD_X,    cond: COND_ALWAYS,    target: STEP_DIV_X};
         STEP_DIV_X:     w = '{op: OP_DIVIDE,    cond: COND_DIV_LAST,  target: STEP_STORE_CX};
         STEP_STORE_CX:  w = '{op: OP_STORE_CX,  cond: COND_ALWAYS,    target: STEP_LOAD_Y};
         STEP_LOAD_Y:    w = '{op: OP_LOAD_Y,    cond: COND_ALWAYS,    target: STEP_DIV_Y};
         STEP_DIV_Y:     w = '{op: OP_DIVIDE,    cond: COND_DIV_LAST,  target: STEP_STORE_CY};
         STEP_STORE_CY:  w = '{op: OP_STORE_CY,  cond: COND_ALWAYS,    target: STEP_ITERATE};
         STEP_ITERATE:   w = '{op: OP_ITERATE,   cond: COND_ITER_DONE, target: STEP_LOAD_GREY};
         STEP_LOAD_GREY: w = '{op: OP_LOAD_GREY, cond: COND_ALWAYS,    target: STEP_DIV_GREY};
         STEP_DIV_GREY:  w = '{op: OP_DIVIDE,    cond: COND_DIV_LAST,  target: STEP_EMIT};
         STEP_EMIT:      w = '{op: OP_EMIT,      cond: COND_ALWAYS,    target: STEP_IDLE};
         default:        w = '{op: OP_IDLE,      cond: COND_ALWAYS,    target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/mandelbrot_escape_time_pixel_top.sv */
// Mandelbrot escape-time pixel: microcoded sequencer over a shift-subtract divider and an iterator.
// Depends on mandel_pkg. The result beat follows the escape loop and the grey-level division; a new
// pixel is taken on start only once the sequencer is back in idle.
// The iterator does one z = z*z + c step per cycle; the divider resolves one quotient bit per
// cycle (DIM_BITS + FRAC + 1 per coordinate, 8 for the grey level).
// Reset: synchronous; clears the sequencer and the result strobe, registers go to 640/480/1000.
module mandelbrot_escape_time_pixel_top
   import mandel_pkg::*;
#(
   parameter int FRAC_BITS = 28
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_payload_type          req_data,
   output logic                     rsp_valid,
   output rsp_payload_type          rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int FRAC      = (FRAC_BITS > 28) ? 28 : FRAC_BITS;
   localparam int C_BITS    = FRAC + 4;
   localparam int Z_BITS    = FRAC + 5;
   localparam int OPND_BITS = FRAC + 3;
   localparam int PROD_BITS = 2 * OPND_BITS;
   localparam int SQ_BITS   = 2 * FRAC + 4;
   localparam int NUM_BITS  = DIM_BITS + FRAC + 1;
   localparam int DCNT_BITS = $clog2(NUM_BITS + 1);

   localparam logic [NUM_BITS-1:0]      C_SAT   = NUM_BITS'(1) << (FRAC + 2);
   localparam logic signed [Z_BITS-1:0] Z_HI    = Z_BITS'(1) << (FRAC + 1);
   localparam logic signed [Z_BITS-1:0] Z_LO    = -Z_HI;
   localparam logic [SQ_BITS-1:0]       ESC_LIM = SQ_BITS'(1) << (2 * FRAC + 2);

   pc_type    pc_ff, pc_in;
   uword_type uw;

   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [ITER_BITS-1:0] max_ff;
   logic [DIM_BITS-1:0]  pix_x_ff, pix_y_ff;

   logic [DEN_BITS-1:0]  div_rem_ff, div_rem_in;
   logic [NUM_BITS-1:0]  div_num_ff, div_quo_ff;
   logic [DEN_BITS-1:0]  div_den_ff;
   logic [DCNT_BITS-1:0] div_cnt_ff;
   logic [DEN_BITS:0]    div_shift, div_diff;
   logic                 div_ge, div_last;

   logic [DIM_BITS-1:0]  coord_pos, coord_half, coord_mag;
   logic [SIZE_BITS-1:0] coord_size, coord_nz, coord_off, coord_abs;
   logic                 coord_neg, coord_neg_ff;
   logic [NUM_BITS-1:0]  c_mag;
   logic [C_BITS-1:0]    c_val;

   logic signed [C_BITS-1:0]    cx_ff, cy_ff;
   logic signed [Z_BITS-1:0]    zx_ff, zy_ff, zx_in, zy_in;
   logic signed [OPND_BITS-1:0] ax, ay;
   logic signed [PROD_BITS-1:0] sq_x, sq_y, prod_xy, sq_diff, re_part, im_part;
   logic [SQ_BITS-1:0]          sq_sum;
   logic [ITER_BITS-1:0]        iter_ff;
   logic                        z_out, escaped, iter_done;
   logic [COUNT_BITS-1:0]       count_ff;
   logic                        grey_sat_ff;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // sequencer
   always_comb begin
      uw = ucode(pc_ff);
   end

   always_comb begin
      pc_in = pc_ff;
      case (uw.cond)
         COND_ALWAYS:    pc_in = uw.target;
         COND_START:     if (start) pc_in = uw.target;
         COND_DIV_LAST:  if (div_last) pc_in = uw.target;
         COND_ITER_DONE: if (iter_done) pc_in = uw.target;
         default:        pc_in = STEP_IDLE;
      endcase
   end

   always_comb begin
      busy      = (pc_ff != STEP_IDLE);
      csr_ready = (pc_ff == STEP_IDLE);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= (uw.op == OP_EMIT);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         max_ff    <= MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_MAX_ITERATIONS: max_ff    <= csr_wdata[ITER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // coordinate offset from the image centre
   always_comb begin
      coord_pos  = (uw.op == OP_LOAD_Y) ? pix_y_ff : pix_x_ff;
      coord_size = (uw.op == OP_LOAD_Y) ? height_ff : width_ff;
      coord_nz   = (coord_size == '0) ? SIZE_BITS'(1) : coord_size;
      coord_half = coord_nz[SIZE_BITS-1:1];
      coord_off  = {1'b0, coord_pos} - {1'b0, coord_half};
      coord_neg  = coord_off[SIZE_BITS-1];
      coord_abs  = coord_neg ? (~coord_off + SIZE_BITS'(1)) : coord_off;
      coord_mag  = coord_abs[DIM_BITS-1:0];
   end

   // divider step and quotient saturation
   always_comb begin
      div_shift  = {div_rem_ff, div_num_ff[NUM_BITS-1]};
      div_ge     = (div_shift >= {1'b0, div_den_ff});
      div_diff   = div_shift - {1'b0, div_den_ff};
      div_rem_in = div_ge ? div_diff[DEN_BITS-1:0] : div_shift[DEN_BITS-1:0];
      div_last   = (div_cnt_ff == DCNT_BITS'(1));
      c_mag      = (div_quo_ff > C_SAT) ? C_SAT : div_quo_ff;
      c_val      = coord_neg_ff ? (~c_mag[C_BITS-1:0] + C_BITS'(1)) : c_mag[C_BITS-1:0];
   end

   // one z = z*z + c step; escape is judged on the z held now
   always_comb begin
      ax        = zx_ff[OPND_BITS-1:0];
      ay        = zy_ff[OPND_BITS-1:0];
      sq_x      = ax * ax;
      sq_y      = ay * ay;
      prod_xy   = ax * ay;
      sq_sum    = {1'b0, sq_x[SQ_BITS-2:0]} + {1'b0, sq_y[SQ_BITS-2:0]};
      z_out     = (zx_ff < Z_LO) || (zx_ff > Z_HI) || (zy_ff < Z_LO) || (zy_ff > Z_HI);
      escaped   = z_out || (sq_sum > ESC_LIM);
      iter_done = escaped || (iter_ff == max_ff);
      sq_diff   = sq_x - sq_y;
      re_part   = sq_diff >>> FRAC;
      im_part   = prod_xy >>> (FRAC - 1);
      zx_in     = re_part[Z_BITS-1:0] + {{(Z_BITS - C_BITS){cx_ff[C_BITS-1]}}, cx_ff};
      zy_in     = im_part[Z_BITS-1:0] + {{(Z_BITS - C_BITS){cy_ff[C_BITS-1]}}, cy_ff};
   end

   // datapath
   always_ff @(posedge clock) begin
      case (uw.op)
         OP_IDLE: begin
            if (start) begin
               pix_x_ff <= req_data.pixel_x;
               pix_y_ff <= req_data.pixel_y;
            end
         end
         OP_LOAD_X, OP_LOAD_Y: begin
            div_rem_ff   <= '0;
            div_num_ff   <= {coord_mag, (FRAC + 1)'(coord_half)};
            div_den_ff   <= DEN_BITS'(coord_nz);
            div_cnt_ff   <= DCNT_BITS'(NUM_BITS);
            coord_neg_ff <= coord_neg;
         end
         OP_DIVIDE: begin
            div_rem_ff <= div_rem_in;
            div_num_ff <= {div_num_ff[NUM_BITS-2:0], 1'b0};
            div_quo_ff <= {div_quo_ff[NUM_BITS-2:0], div_ge};
            div_cnt_ff <= div_cnt_ff - DCNT_BITS'(1);
         end
         OP_STORE_CX: begin
            cx_ff <= c_val;
         end
         OP_STORE_CY: begin
            cy_ff   <= c_val;
            zx_ff   <= '0;
            zy_ff   <= '0;
            iter_ff <= '0;
         end
         OP_ITERATE: begin
            if (iter_done) begin
               count_ff <= escaped ? {1'b0, iter_ff} : ({1'b0, max_ff} + COUNT_BITS'(1));
            end else begin
               zx_ff   <= zx_in;
               zy_ff   <= zy_in;
               iter_ff <= iter_ff + ITER_BITS'(1);
            end
         end
         OP_LOAD_GREY: begin
            div_rem_ff  <= count_ff[ITER_BITS-1:0];
            div_num_ff  <= '0;
            div_den_ff  <= max_ff;
            div_cnt_ff  <= DCNT_BITS'(GREY_BITS);
            grey_sat_ff <= (count_ff >= {1'b0, max_ff});
         end
         OP_EMIT: begin
            rsp_data_ff.iteration_count <= count_ff;
            rsp_data_ff.grey_level      <= grey_sat_ff ? '1 : div_quo_ff[GREY_BITS-1:0];
         end
         default: ;
      endcase
   end

endmodule

/* rtl/core/mandel_checker.sv */
// Port-level checker for the escape-time pixel top level, with its bind.
// Depends on mandel_pkg and mandelbrot_escape_time_pixel_top_defines.svh.
`include "mandelbrot_escape_time_pixel_top_defines.svh"

module mandel_checker
   import mandel_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_valid,
   input rsp_payload_type rsp_data
);

   `MANDEL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "taken beat did not raise busy")
   `MANDEL_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe held")
   `MANDEL_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_valid, !busy, "result beat while busy")
   `MANDEL_ASSERT_NEXT(a_busy_ends_beat, clock, reset, busy, busy || rsp_valid, "busy dropped without beat")
   `MANDEL_ASSERT_NOW(a_count_nonzero, clock, reset, rsp_valid, rsp_data.iteration_count != '0, "zero count")

endmodule

bind mandelbrot_escape_time_pixel_top mandel_checker u_mandel_checker (.*);
